// ===== src/swd_host_sequencer_assert.svh =====
// Assertion macros for the SWD host sequencer checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef SWD_HOST_SEQUENCER_ASSERT_SVH
`define SWD_HOST_SEQUENCER_ASSERT_SVH

// Same-cycle implication, reset masked
`define SWD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swd_host_sequencer: same-cycle check failed");

// Next-cycle implication, reset masked
`define SWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swd_host_sequencer: next-cycle check failed");

`endif

// ===== src/swd_pkg.sv =====
// Shared types and constants for the SWD host sequencer.
// No dependencies; used by swd_step, swd_host_sequencer and swd_checker.
package swd_pkg;

  // Timing constants
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] LINE_RESET_LEN = 8'd60;
  localparam logic [CNT_W-1:0] IDLE_CYCLES    = 8'd8;
  localparam logic [CNT_W-1:0] SWITCH_BITS    = 8'd16;
  localparam logic [CNT_W-1:0] REQ_BITS       = 8'd8;
  localparam logic [CNT_W-1:0] ACK_BITS       = 8'd3;
  localparam logic [CNT_W-1:0] DATA_BITS      = 8'd32;
  localparam logic [15:0]      SWITCH_WORD    = 16'hE79E;

  // Command codes
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_XFER   = 2'd1;
  localparam logic [1:0] OP_LRESET = 2'd2;
  localparam logic [1:0] OP_JTAG   = 2'd3;

  // Acknowledge code for OK
  localparam logic [2:0] ACK_OK = 3'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic        is_ap;
    logic        is_read;
    logic [1:0]  addr_bits;
    logic [31:0] write_data;
    logic        dio_in;
  } swd_in_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        dio_out;
    logic        dio_drive;
    logic        done_res;
    logic        ok;
    logic [2:0]  ack;
    logic        par_err;
    logic [31:0] read_data;
  } swd_out_t;

  // Build the request byte, LSB sent first: start, APnDP, RnW, A2, A3, parity, stop, park
  function automatic logic [7:0] req_encode(input logic ap, input logic rd,
                                            input logic [1:0] addr);
    logic par;
    par = ap ^ rd ^ addr[0] ^ addr[1];
    return {1'b1, 1'b0, par, addr[1], addr[0], rd, ap, 1'b1};
  endfunction

endpackage

// ===== src/swd_host_sequencer.sv =====
// SWD host sequencer: one input word per SWCLK bit period, one result word per input.
// A word on in_data reaches out_data through the input register and the result
// register; out_valid rises when the accepted word moves into the result register.
// Throughput: one word per cycle while out_ready is high; step logic is combinational.
// Reset (rst_n low, synchronous): sequencer idle, line driven high, both stages empty.
// Depends on swd_pkg and swd_step.
module swd_host_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swd_pkg::swd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swd_pkg::swd_out_t  out_data
);

  logic               in_valid_r;
  swd_pkg::swd_in_t   in_data_r;
  logic               out_valid_r;
  swd_pkg::swd_out_t  out_data_r;
  swd_pkg::swd_out_t  step_res;
  logic               advance;

  // Move a word into the result register when it is free or being taken
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  swd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .res     (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/swd_step.sv =====
// SWD bit-period sequencer: phase state and one-period next-state/result logic.
// Depends on swd_pkg for payload types, command codes and timing constants.
module swd_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  swd_pkg::swd_in_t   item,
  output swd_pkg::swd_out_t  res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_LRESET, PH_JTAG, PH_REQ, PH_TRN1, PH_ACK, PH_FAILTRN,
    PH_RDATA, PH_RPAR, PH_RTRN, PH_WTRN, PH_WDATA, PH_WPAR, PH_TAIL
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [swd_pkg::CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [swd_pkg::CNT_W-1:0]  cnt_inc;
  logic [31:0]                shift_r, shift_nxt;
  logic                       par_r, par_nxt;
  logic [2:0]                 ack_r, ack_nxt;
  logic                       rd_flag_r, rd_flag_nxt;
  logic                       line_r, line_nxt;
  logic                       drive_r, drive_nxt;
  logic [7:0]                 req_r, req_nxt;
  logic                       bit_v;
  logic                       fin_ok;

  // Work out one bit period
  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    par_nxt     = par_r;
    ack_nxt     = ack_r;
    rd_flag_nxt = rd_flag_r;
    line_nxt    = line_r;
    drive_nxt   = drive_r;
    req_nxt     = req_r;
    res         = '0;
    fin_ok      = 1'b0;
    bit_v       = 1'b0;

    // Take a command while idle; unused phase codes count as idle
    if (phase_r == PH_IDLE || phase_r > PH_TAIL) begin
      phase_nxt = PH_IDLE;
      if (item.op != swd_pkg::OP_NONE) begin
        bit_cnt_nxt = '0;
        drive_nxt   = 1'b1;
        case (item.op)
          swd_pkg::OP_XFER: begin
            req_nxt     = swd_pkg::req_encode(item.is_ap, item.is_read, item.addr_bits);
            rd_flag_nxt = item.is_read;
            shift_nxt   = item.write_data;
            ack_nxt     = '0;
            phase_nxt   = PH_REQ;
          end
          swd_pkg::OP_LRESET: begin
            phase_nxt = PH_LRESET;
          end
          default: begin
            phase_nxt = PH_JTAG;
          end
        endcase
      end
    end

    cnt_inc = bit_cnt_nxt + 1'b1;

    case (phase_nxt)
      PH_LRESET: begin
        line_nxt    = 1'b1;
        bit_cnt_nxt = cnt_inc;
        res.clock_pulse = 1'b1;
        res.dio_out     = 1'b1;
        res.dio_drive   = 1'b1;
        if (cnt_inc >= swd_pkg::LINE_RESET_LEN) begin
          phase_nxt    = PH_IDLE;
          res.done_res = 1'b1;
          res.ok       = 1'b1;
        end
      end
      PH_JTAG: begin
        bit_v       = swd_pkg::SWITCH_WORD[bit_cnt_nxt[3:0]];
        line_nxt    = bit_v;
        bit_cnt_nxt = cnt_inc;
        res.clock_pulse = 1'b1;
        res.dio_out     = bit_v;
        res.dio_drive   = 1'b1;
        if (cnt_inc >= swd_pkg::SWITCH_BITS) begin
          phase_nxt    = PH_IDLE;
          res.done_res = 1'b1;
          res.ok       = 1'b1;
        end
      end
      PH_REQ: begin
        bit_v       = req_nxt[bit_cnt_nxt[2:0]];
        line_nxt    = bit_v;
        bit_cnt_nxt = cnt_inc;
        if (cnt_inc >= swd_pkg::REQ_BITS) begin
          phase_nxt = PH_TRN1;
        end
        res.clock_pulse = 1'b1;
        res.dio_out     = bit_v;
        res.dio_drive   = 1'b1;
      end
      PH_TRN1: begin
        drive_nxt   = 1'b0;
        bit_cnt_nxt = '0;
        ack_nxt     = '0;
        phase_nxt   = PH_ACK;
        res.clock_pulse = 1'b1;
      end
      PH_ACK: begin
        // Sample ack LSB first
        if (bit_cnt_nxt[1:0] != 2'd3) begin
          ack_nxt[bit_cnt_nxt[1:0]] = ack_nxt[bit_cnt_nxt[1:0]] | item.dio_in;
        end
        bit_cnt_nxt = cnt_inc;
        if (cnt_inc >= swd_pkg::ACK_BITS) begin
          bit_cnt_nxt = '0;
          par_nxt     = 1'b0;
          if (ack_nxt != swd_pkg::ACK_OK) begin
            phase_nxt = PH_FAILTRN;
          end else if (rd_flag_nxt) begin
            shift_nxt = '0;
            phase_nxt = PH_RDATA;
          end else begin
            phase_nxt = PH_WTRN;
          end
        end
        res.clock_pulse = 1'b1;
      end
      PH_FAILTRN: begin
        drive_nxt    = 1'b1;
        phase_nxt    = PH_IDLE;
        res.clock_pulse = 1'b1;
        res.done_res    = 1'b1;
        res.ack         = ack_nxt;
      end
      PH_RDATA: begin
        shift_nxt[bit_cnt_nxt[4:0]] = shift_nxt[bit_cnt_nxt[4:0]] | item.dio_in;
        par_nxt     = par_nxt ^ item.dio_in;
        bit_cnt_nxt = cnt_inc;
        if (cnt_inc >= swd_pkg::DATA_BITS) begin
          phase_nxt = PH_RPAR;
        end
        res.clock_pulse = 1'b1;
      end
      PH_RPAR: begin
        par_nxt   = par_nxt ^ item.dio_in;
        phase_nxt = PH_RTRN;
        res.clock_pulse = 1'b1;
      end
      PH_RTRN: begin
        drive_nxt = 1'b1;
        res.clock_pulse = 1'b1;
        if (par_nxt) begin
          phase_nxt    = PH_IDLE;
          res.done_res = 1'b1;
          res.ack      = ack_nxt;
          res.par_err  = 1'b1;
        end else if (swd_pkg::IDLE_CYCLES == '0) begin
          fin_ok = 1'b1;
        end else begin
          bit_cnt_nxt = '0;
          phase_nxt   = PH_TAIL;
        end
      end
      PH_WTRN: begin
        drive_nxt   = 1'b1;
        bit_cnt_nxt = '0;
        par_nxt     = 1'b0;
        phase_nxt   = PH_WDATA;
        res.clock_pulse = 1'b1;
      end
      PH_WDATA: begin
        bit_v       = shift_nxt[bit_cnt_nxt[4:0]];
        par_nxt     = par_nxt ^ bit_v;
        line_nxt    = bit_v;
        bit_cnt_nxt = cnt_inc;
        if (cnt_inc >= swd_pkg::DATA_BITS) begin
          phase_nxt = PH_WPAR;
        end
        res.clock_pulse = 1'b1;
        res.dio_out     = bit_v;
        res.dio_drive   = 1'b1;
      end
      PH_WPAR: begin
        bit_v    = par_nxt;
        line_nxt = bit_v;
        res.clock_pulse = 1'b1;
        res.dio_out     = bit_v;
        res.dio_drive   = 1'b1;
        if (swd_pkg::IDLE_CYCLES == '0) begin
          fin_ok = 1'b1;
        end else begin
          bit_cnt_nxt = '0;
          phase_nxt   = PH_TAIL;
        end
      end
      PH_TAIL: begin
        line_nxt    = 1'b0;
        bit_cnt_nxt = cnt_inc;
        res.clock_pulse = 1'b1;
        res.dio_drive   = 1'b1;
        if (cnt_inc >= swd_pkg::IDLE_CYCLES) begin
          fin_ok = 1'b1;
        end
      end
      default: begin
        // Idle period: no clock, hold the line
        phase_nxt     = PH_IDLE;
        res.dio_out   = line_r;
        res.dio_drive = drive_r;
      end
    endcase

    // Close a successful sequence
    if (fin_ok) begin
      line_nxt      = 1'b0;
      drive_nxt     = 1'b1;
      phase_nxt     = PH_IDLE;
      res.done_res  = 1'b1;
      res.ok        = 1'b1;
      res.ack       = ack_nxt;
      res.read_data = rd_flag_nxt ? shift_nxt : '0;
    end
  end

  // Hold sequencer state; advance once per accepted bit period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      par_r     <= 1'b0;
      ack_r     <= '0;
      rd_flag_r <= 1'b0;
      line_r    <= 1'b1;
      drive_r   <= 1'b1;
      req_r     <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      par_r     <= par_nxt;
      ack_r     <= ack_nxt;
      rd_flag_r <= rd_flag_nxt;
      line_r    <= line_nxt;
      drive_r   <= drive_nxt;
      req_r     <= req_nxt;
    end
  end

endmodule

// ===== src/swd_checker.sv =====
// Port-level checks for the SWD host sequencer, bound to the top level.
// Depends on swd_pkg and swd_host_sequencer_assert.svh.
`include "swd_host_sequencer_assert.svh"

module swd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input swd_pkg::swd_out_t  out_data
);

  logic status_clear;
  logic idle_quiet;

  // Gather the status fields that stay clear between closes
  assign status_clear = !out_data.ok && (out_data.ack == 3'd0) && !out_data.par_err
                        && (out_data.read_data == 32'd0);
  assign idle_quiet   = out_data.dio_drive && !out_data.done_res;

  // A stalled result holds its word
  `SWD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Status fields stay clear except on the closing period
  `SWD_ASSERT_NOW(a_status_quiet, out_valid && !out_data.done_res, status_clear)

  // A successful close never flags parity
  `SWD_ASSERT_NOW(a_ok_no_perr, out_valid && out_data.done_res && out_data.ok, !out_data.par_err)

  // Idle periods have the host driving and nothing finishing
  `SWD_ASSERT_NOW(a_idle_drive, out_valid && !out_data.clock_pulse, idle_quiet)

  // A released line shows a low level
  `SWD_ASSERT_NOW(a_release_low, out_valid && !out_data.dio_drive, !out_data.dio_out)

endmodule

bind swd_host_sequencer swd_checker u_swd_checker (.*);

// ===== tb/sv/swd_host_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for swd_host_sequencer: plays the SWD target on dio_in,
// predicts every result word and compares it field by field. Depends on swd_pkg.

module swd_host_sequencer_tb;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned END_WAIT = 8;

  // Bit-period phases of the host sequence
  typedef enum logic [3:0] {
    ST_IDLE, ST_LINE_RESET, ST_SWITCH, ST_REQUEST, ST_TURN_ACK, ST_ACK, ST_TURN_FAIL,
    ST_READ_DATA, ST_READ_PARITY, ST_TURN_READ, ST_TURN_WRITE, ST_WRITE_DATA,
    ST_WRITE_PARITY, ST_IDLE_TAIL
  } seq_phase_t;

  // One command as the target side will answer it
  typedef struct {
    logic [1:0]         op;
    logic               ap;
    logic               rd;
    logic [1:0]         addr;
    logic [31:0]        wdata;
    logic [2:0]         ack_resp;
    logic [31:0]        rdata;
    logic               flip_par;
    bit                 typed;
    swd_pkg::swd_out_t  typed_res;
  } swd_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  swd_pkg::swd_in_t   in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  swd_pkg::swd_out_t  out_data;

  // Predicted sequencer state
  seq_phase_t                 ph = ST_IDLE;
  logic [swd_pkg::CNT_W-1:0]  bit_cnt = '0;
  logic [31:0]                data_sr = '0;
  logic                       par_acc = 1'b0;
  logic [2:0]                 ack_rx = '0;
  logic                       rd_xfer = 1'b0;
  logic                       line_lvl = 1'b1;
  logic                       host_drv = 1'b1;
  logic [7:0]                 req_bits = '0;

  swd_pkg::swd_out_t  expected_results[$];
  swd_cmd_t           plan[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned n_xfer = 0, n_read = 0, n_ack_fail = 0, n_par_err = 0;
  int unsigned n_lreset = 0, n_switch = 0;
  bit          steady_send = 1'b0;
  int unsigned rdy_left = 0;
  logic        rdy_lvl = 1'b0;

  swd_host_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Close the current sequence successfully
  function automatic swd_pkg::swd_out_t finish_good(logic dout, logic drv);
    swd_pkg::swd_out_t r;
    r = '0;
    line_lvl = 1'b0;
    host_drv = 1'b1;
    ph = ST_IDLE;
    r.clock_pulse = 1'b1;
    r.dio_out = dout;
    r.dio_drive = drv;
    r.done_res = 1'b1;
    r.ok = 1'b1;
    r.ack = ack_rx;
    r.read_data = rd_xfer ? data_sr : 32'h0;
    return r;
  endfunction

  // Advance the predicted sequencer by one bit period
  function automatic swd_pkg::swd_out_t predict_period(swd_pkg::swd_in_t w);
    swd_pkg::swd_out_t r;
    logic              b;
    r = '0;
    if (ph == ST_IDLE) begin
      if (w.op == swd_pkg::OP_NONE) begin
        r.dio_out = line_lvl;
        r.dio_drive = host_drv;
        return r;
      end
      bit_cnt = '0;
      host_drv = 1'b1;
      case (w.op)
        swd_pkg::OP_XFER: begin
          req_bits[0] = 1'b1;
          req_bits[1] = w.is_ap;
          req_bits[2] = w.is_read;
          req_bits[3] = w.addr_bits[0];
          req_bits[4] = w.addr_bits[1];
          req_bits[5] = ^{w.is_ap, w.is_read, w.addr_bits};
          req_bits[6] = 1'b0;
          req_bits[7] = 1'b1;
          rd_xfer = w.is_read;
          data_sr = w.write_data;
          ack_rx = '0;
          ph = ST_REQUEST;
        end
        swd_pkg::OP_LRESET: ph = ST_LINE_RESET;
        default: ph = ST_SWITCH;
      endcase
    end
    r.clock_pulse = 1'b1;
    case (ph)
      ST_LINE_RESET: begin
        line_lvl = 1'b1;
        bit_cnt++;
        r.dio_out = 1'b1;
        r.dio_drive = 1'b1;
        if (bit_cnt >= swd_pkg::LINE_RESET_LEN) begin
          ph = ST_IDLE;
          r.done_res = 1'b1;
          r.ok = 1'b1;
        end
      end
      ST_SWITCH: begin
        b = swd_pkg::SWITCH_WORD[bit_cnt[3:0]];
        line_lvl = b;
        bit_cnt++;
        r.dio_out = b;
        r.dio_drive = 1'b1;
        if (bit_cnt >= swd_pkg::SWITCH_BITS) begin
          ph = ST_IDLE;
          r.done_res = 1'b1;
          r.ok = 1'b1;
        end
      end
      ST_REQUEST: begin
        b = req_bits[bit_cnt[2:0]];
        line_lvl = b;
        bit_cnt++;
        if (bit_cnt >= swd_pkg::REQ_BITS) ph = ST_TURN_ACK;
        r.dio_out = b;
        r.dio_drive = 1'b1;
      end
      ST_TURN_ACK: begin
        host_drv = 1'b0;
        bit_cnt = '0;
        ack_rx = '0;
        ph = ST_ACK;
      end
      ST_ACK: begin
        ack_rx = ack_rx | (3'(w.dio_in) << bit_cnt[1:0]);
        bit_cnt++;
        if (bit_cnt >= swd_pkg::ACK_BITS) begin
          bit_cnt = '0;
          par_acc = 1'b0;
          if (ack_rx != swd_pkg::ACK_OK) begin
            ph = ST_TURN_FAIL;
          end else if (rd_xfer) begin
            data_sr = '0;
            ph = ST_READ_DATA;
          end else begin
            ph = ST_TURN_WRITE;
          end
        end
      end
      ST_TURN_FAIL: begin
        host_drv = 1'b1;
        ph = ST_IDLE;
        r.done_res = 1'b1;
        r.ack = ack_rx;
      end
      ST_READ_DATA: begin
        data_sr[bit_cnt[4:0]] = w.dio_in;
        par_acc ^= w.dio_in;
        bit_cnt++;
        if (bit_cnt >= swd_pkg::DATA_BITS) ph = ST_READ_PARITY;
      end
      ST_READ_PARITY: begin
        par_acc ^= w.dio_in;
        ph = ST_TURN_READ;
      end
      ST_TURN_READ: begin
        host_drv = 1'b1;
        if (par_acc) begin
          ph = ST_IDLE;
          r.done_res = 1'b1;
          r.ack = ack_rx;
          r.par_err = 1'b1;
        end else if (swd_pkg::IDLE_CYCLES == 0) begin
          r = finish_good(1'b0, 1'b0);
        end else begin
          bit_cnt = '0;
          ph = ST_IDLE_TAIL;
        end
      end
      ST_TURN_WRITE: begin
        host_drv = 1'b1;
        bit_cnt = '0;
        par_acc = 1'b0;
        ph = ST_WRITE_DATA;
      end
      ST_WRITE_DATA: begin
        b = data_sr[bit_cnt[4:0]];
        par_acc ^= b;
        line_lvl = b;
        bit_cnt++;
        if (bit_cnt >= swd_pkg::DATA_BITS) ph = ST_WRITE_PARITY;
        r.dio_out = b;
        r.dio_drive = 1'b1;
      end
      ST_WRITE_PARITY: begin
        b = par_acc;
        line_lvl = b;
        r.dio_out = b;
        r.dio_drive = 1'b1;
        if (swd_pkg::IDLE_CYCLES == 0) begin
          r = finish_good(b, 1'b1);
        end else begin
          bit_cnt = '0;
          ph = ST_IDLE_TAIL;
        end
      end
      ST_IDLE_TAIL: begin
        line_lvl = 1'b0;
        bit_cnt++;
        r.dio_drive = 1'b1;
        if (bit_cnt >= swd_pkg::IDLE_CYCLES) r = finish_good(1'b0, 1'b1);
      end
      default: begin
        ph = ST_IDLE;
        r = '0;
        r.dio_out = line_lvl;
        r.dio_drive = host_drv;
      end
    endcase
    return r;
  endfunction

  function automatic swd_cmd_t mk_cmd(logic [1:0] op, logic ap, logic rd, logic [1:0] addr,
                                      logic [31:0] wdata, logic [2:0] ack_resp,
                                      logic [31:0] rdata, logic flip_par, bit typed,
                                      swd_pkg::swd_out_t typed_res);
    swd_cmd_t c;
    c.op = op;
    c.ap = ap;
    c.rd = rd;
    c.addr = addr;
    c.wdata = wdata;
    c.ack_resp = ack_resp;
    c.rdata = rdata;
    c.flip_par = flip_par;
    c.typed = typed;
    c.typed_res = typed_res;
    return c;
  endfunction

  function automatic swd_pkg::swd_out_t typed_out(logic clkp, logic dout, logic drv,
                                                  logic done, logic okv, logic [2:0] ackv,
                                                  logic perr);
    return {clkp, dout, drv, done, okv, ackv, perr, 32'h0};
  endfunction

  function automatic swd_pkg::swd_in_t rand_word();
    swd_pkg::swd_in_t w;
    w.op = 2'($urandom_range(0, 3));
    w.is_ap = 1'($urandom_range(0, 1));
    w.is_read = 1'($urandom_range(0, 1));
    w.addr_bits = 2'($urandom_range(0, 3));
    w.write_data = $urandom;
    w.dio_in = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one word, hold it until taken, then predict its result
  task automatic send_word(input swd_pkg::swd_in_t w, input bit typed,
                           input swd_pkg::swd_out_t typed_res);
    int unsigned       gap;
    swd_pkg::swd_out_t pred;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    items_sent++;
    pred = predict_period(w);
    // A typed row replaces the closing result, or the single result of an idle word
    if (typed && (pred.done_res || !pred.clock_pulse)) expected_results.push_back(typed_res);
    else expected_results.push_back(pred);
  endtask

  // Run one command to its end, answering as the target
  task automatic run_command(input swd_cmd_t c);
    swd_pkg::swd_in_t w;
    if (c.op == swd_pkg::OP_XFER) begin
      n_xfer++;
      if (c.rd) n_read++;
      if (c.ack_resp != swd_pkg::ACK_OK) n_ack_fail++;
      else if (c.rd && c.flip_par) n_par_err++;
    end else if (c.op == swd_pkg::OP_LRESET) begin
      n_lreset++;
    end else if (c.op == swd_pkg::OP_JTAG) begin
      n_switch++;
    end
    w = rand_word();
    w.op = c.op;
    w.is_ap = c.ap;
    w.is_read = c.rd;
    w.addr_bits = c.addr;
    w.write_data = c.wdata;
    send_word(w, c.typed, c.typed_res);
    while (ph != ST_IDLE) begin
      w = rand_word();
      case (ph)
        ST_ACK: w.dio_in = c.ack_resp[bit_cnt[1:0]];
        ST_READ_DATA: w.dio_in = c.rdata[bit_cnt[4:0]];
        ST_READ_PARITY: w.dio_in = ^c.rdata ^ c.flip_par;
        default: ;
      endcase
      send_word(w, c.typed, c.typed_res);
    end
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic void field_chk(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      mismatches++;
    end
  endfunction

  // Result side: random stalls, long ready stretches now and then
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1: begin rdy_lvl = 1'b1; rdy_left = $urandom_range(50, 200); end
        2, 3, 4, 5: begin rdy_lvl = 1'b1; rdy_left = $urandom_range(1, 8); end
        6, 7, 8: begin rdy_lvl = 1'b0; rdy_left = $urandom_range(1, 3); end
        default: begin rdy_lvl = 1'b0; rdy_left = $urandom_range(10, 40); end
      endcase
    end
    rdy_left--;
    out_ready <= rdy_lvl;
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    swd_pkg::swd_out_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result word %h arrived with nothing expected", out_data);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        field_chk("clock_pulse", e.clock_pulse, out_data.clock_pulse);
        field_chk("dio_out", e.dio_out, out_data.dio_out);
        field_chk("dio_drive", e.dio_drive, out_data.dio_drive);
        field_chk("done_res", e.done_res, out_data.done_res);
        field_chk("ok", e.ok, out_data.ok);
        field_chk("ack", e.ack, out_data.ack);
        field_chk("par_err", e.par_err, out_data.par_err);
        field_chk("read_data", e.read_data, out_data.read_data);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Run timed out with %0d results outstanding", expected_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    swd_cmd_t    c;
    int unsigned start_items;
    int unsigned k;
    logic [2:0]  a;
    logic [31:0] rdata;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed commands: extremes, every operation, every way to fail
    plan.push_back(mk_cmd(swd_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0, 1,
                          typed_out(0, 1, 1, 0, 0, 0, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_LRESET, 0, 0, 0, 0, 0, 0, 0, 1,
                          typed_out(1, 1, 1, 1, 1, 0, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_JTAG, 0, 0, 0, 0, 0, 0, 0, 1,
                          typed_out(1, 1, 1, 1, 1, 0, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_NONE, 1, 1, 3, '1, 7, 0, 0, 1,
                          typed_out(0, 1, 1, 0, 0, 0, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 0, 1, 0, 0, swd_pkg::ACK_OK, 32'h0, 0, 0, '0));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 1, 1, 3, '1, swd_pkg::ACK_OK, 32'hFFFF_FFFF,
                          0, 0, '0));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 0, 0, 1, 32'h0, swd_pkg::ACK_OK, '1, 0, 0, '0));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 1, 0, 2, 32'hFFFF_FFFF, swd_pkg::ACK_OK, 0,
                          0, 0, '0));
    plan.push_back(mk_cmd(swd_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0, 1,
                          typed_out(0, 0, 1, 0, 0, 0, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 0, 1, 1, 0, 3'd4, '1, 0, 1,
                          typed_out(1, 0, 0, 1, 0, 4, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 1, 0, 2, '1, 3'd2, 0, 0, 1,
                          typed_out(1, 0, 0, 1, 0, 2, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 1, 1, 0, 0, 3'd0, 0, 0, 1,
                          typed_out(1, 0, 0, 1, 0, 0, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 0, 0, 3, 5, 3'd7, 0, 0, 1,
                          typed_out(1, 0, 0, 1, 0, 7, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 0, 1, 2, 0, swd_pkg::ACK_OK, 32'h1234_5678, 1, 1,
                          typed_out(1, 0, 0, 1, 0, swd_pkg::ACK_OK, 1)));
    // Line holds the park bit after a transfer that failed on parity
    plan.push_back(mk_cmd(swd_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0, 1,
                          typed_out(0, 1, 1, 0, 0, 0, 0)));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 0, 1, 3, '1, swd_pkg::ACK_OK, 32'h0000_0001,
                          0, 0, '0));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 1, 0, 3, 32'h8000_0001, swd_pkg::ACK_OK, '1,
                          0, 0, '0));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 0, 1, 2, 0, swd_pkg::ACK_OK, 32'hA5A5_5A5A,
                          0, 0, '0));
    plan.push_back(mk_cmd(swd_pkg::OP_XFER, 1, 0, 1, 32'h1234_5678, swd_pkg::ACK_OK, 0,
                          1, 0, '0));
    foreach (plan[i]) run_command(plan[i]);
    drain_results();

    // Random commands: mostly well-formed transfers, some failures, line resets, switch words and idle noise
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 3) drain_results();
      if ($urandom_range(0, 99) < 12) steady_send = !steady_send;
      k = $urandom_range(0, 99);
      if (k < 70) begin
        a = swd_pkg::ACK_OK;
        if ($urandom_range(0, 99) < 18) begin
          do a = 3'($urandom_range(0, 7)); while (a == swd_pkg::ACK_OK);
        end
        case ($urandom_range(0, 9))
          0: rdata = 32'h0;
          1: rdata = 32'hFFFF_FFFF;
          default: rdata = $urandom;
        endcase
        c = mk_cmd(swd_pkg::OP_XFER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), $urandom, a, rdata,
                   1'($urandom_range(0, 99) < 15), 0, '0);
        run_command(c);
      end else if (k < 78) begin
        run_command(mk_cmd(swd_pkg::OP_LRESET, 0, 0, 0, $urandom, 0, 0, 0, 0, '0));
      end else if (k < 88) begin
        run_command(mk_cmd(swd_pkg::OP_JTAG, 0, 0, 0, $urandom, 0, 0, 0, 0, '0));
      end else begin
        repeat ($urandom_range(1, 6))
          run_command(mk_cmd(swd_pkg::OP_NONE, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             $urandom, 0, 0, 0, 0, '0));
      end
    end

    // Let the pipeline empty, then watch for stray results
    drain_results();
    repeat (END_WAIT) @(posedge clk);

    $display("Sent %0d bit periods, checked %0d result words", items_sent, results_seen);
    $display("Covered %0d transfers (%0d reads, %0d bad acks, %0d parity errors),",
             n_xfer, n_read, n_ack_fail, n_par_err);
    $display("  %0d line resets and %0d switch words", n_lreset, n_switch);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/swd_pkg.sv
src/swd_step.sv
src/swd_host_sequencer.sv
src/swd_checker.sv
tb/sv/swd_host_sequencer_tb.sv
